[hdl/btct_pkg.sv]
// package for the blob track correlation table
// constants, codes and controller/datapath command types; no dependencies
`timescale 1ns / 1ps

package btct_pkg;

  localparam int MAX_BOXES   = 16;
  localparam int MAX_PENDING = 16;
  localparam int COORD_BITS  = 12;
  localparam int IDX_BITS    = $clog2(MAX_BOXES);
  localparam int CNT_BITS    = $clog2(MAX_BOXES + 1);
  localparam int PIDX_BITS   = $clog2(MAX_PENDING);
  localparam int PCNT_BITS   = $clog2(MAX_PENDING + 1);
  localparam logic [31:0] STALE_RESET = 32'd1000;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_BLOB  = 2'd1,
    ACT_END   = 2'd2,
    ACT_SET   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_MATCH   = 3'd1,
    KIND_QUEUED  = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_RECORD  = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load;       // latch input beat
    logic                 scan_clear; // reset scan indices
    logic                 compact;    // one compaction step (begin / end)
    logic                 stale_mode; // compaction criterion: stale vs aspect
    logic                 finish_compact;
    logic                 match_step;
    logic                 queue_blob;
    logic                 append_step;
    logic                 clear_marks;
    logic                 set_bounds;
    logic                 rpt_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;   // scan index reached box count
    logic hit;         // current scanned entry matches blob
    logic pend_done;   // append finished
    logic rpt_last;    // report index is last box
    logic empty;       // box count is zero
    logic pend_full;
  } dp_stat_t;

endpackage

[hdl/btct_datapath.sv]
// table storage, compaction, match scan, append and report datapath
// depends on btct_pkg
`timescale 1ns / 1ps

module btct_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  btct_pkg::dp_cmd_t        cmd,
  output btct_pkg::dp_stat_t       stat,
  input  logic [31:0]              stale_limit,
  input  logic [1:0]               in_action,
  input  logic [31:0]              in_time,
  input  logic [11:0]              in_x,
  input  logic [11:0]              in_y,
  input  logic [11:0]              in_w,
  input  logic [11:0]              in_h,
  input  logic [3:0]               in_slot,
  output logic [1:0]               act_r,
  output logic [3:0]               rd_slot,
  output logic [11:0]              rd_x,
  output logic [11:0]              rd_y,
  output logic [11:0]              rd_w,
  output logic [11:0]              rd_h,
  output logic [31:0]              rd_first,
  output logic [31:0]              rd_last
);

  localparam int CB = btct_pkg::COORD_BITS;
  localparam int IB = btct_pkg::IDX_BITS;
  localparam int NB = btct_pkg::CNT_BITS;
  localparam int PI = btct_pkg::PIDX_BITS;
  localparam int PN = btct_pkg::PCNT_BITS;

  logic [CB-1:0] left_r [btct_pkg::MAX_BOXES];
  logic [CB-1:0] top_r  [btct_pkg::MAX_BOXES];
  logic [CB-1:0] wide_r [btct_pkg::MAX_BOXES];
  logic [CB-1:0] tall_r [btct_pkg::MAX_BOXES];
  logic [31:0]   ctime_r[btct_pkg::MAX_BOXES];
  logic [31:0]   mtime_r[btct_pkg::MAX_BOXES];
  logic [btct_pkg::MAX_BOXES-1:0] mark_r;
  logic [CB-1:0] px_r [btct_pkg::MAX_PENDING];
  logic [CB-1:0] py_r [btct_pkg::MAX_PENDING];
  logic [CB-1:0] ps_r [btct_pkg::MAX_PENDING];

  logic [NB-1:0] count_r, rd_r, wr_r;
  logic [PN-1:0] pcount_r, pi_r;
  logic [31:0]   frame_r;
  logic [CB-1:0] x_r, y_r, w_r, h_r;
  logic [3:0]    slot_r;

  logic [IB-1:0] ri, wi;
  logic [PI-1:0] pix;
  logic          drop, bad, stale, hit_box;
  logic [CB+4:0] w10, w17, h6, h10x;
  logic [CB:0]   xe, ye;

  assign ri  = rd_r[IB-1:0];
  assign wi  = wr_r[IB-1:0];
  assign pix = pi_r[PI-1:0];

  always_comb begin
    w10  = (CB+5)'(wide_r[ri]) * (CB+5)'(10);
    w17  = (CB+5)'(tall_r[ri]) * (CB+5)'(17);
    h6   = (CB+5)'(tall_r[ri]) * (CB+5)'(6);
    h10x = w10;
    bad  = (wide_r[ri] != '0) && (tall_r[ri] != '0) && ((w10 < h6) || (h10x > w17));
    stale = !mark_r[ri] && ((frame_r - mtime_r[ri]) >= stale_limit);
    drop = cmd.stale_mode ? stale : bad;
    xe = {1'b0, left_r[ri]} + {1'b0, wide_r[ri]};
    ye = {1'b0, top_r[ri]} + {1'b0, tall_r[ri]};
    hit_box = !mark_r[ri] && (x_r >= left_r[ri]) && ({1'b0, x_r} < xe) &&
              (y_r >= top_r[ri]) && ({1'b0, y_r} < ye);
  end

  assign stat.scan_done = (rd_r >= count_r);
  assign stat.hit       = hit_box;
  assign stat.pend_done = (pi_r >= pcount_r) || (count_r >= NB'(btct_pkg::MAX_BOXES));
  assign stat.rpt_last  = (rd_r + NB'(1) == count_r);
  assign stat.empty     = (count_r == '0);
  assign stat.pend_full = (pcount_r >= PN'(btct_pkg::MAX_PENDING));

  assign rd_slot  = 4'(ri);
  assign rd_x     = 12'(left_r[ri]);
  assign rd_y     = 12'(top_r[ri]);
  assign rd_w     = 12'(wide_r[ri]);
  assign rd_h     = 12'(tall_r[ri]);
  assign rd_first = ctime_r[ri];
  assign rd_last  = mtime_r[ri];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pcount_r <= '0;
      frame_r  <= '0;
      mark_r   <= '0;
      rd_r     <= '0;
      wr_r     <= '0;
      pi_r     <= '0;
    end else begin
      if (cmd.load) begin
        act_r  <= in_action;
        x_r    <= CB'(in_x);
        y_r    <= CB'(in_y);
        w_r    <= CB'(in_w);
        h_r    <= CB'(in_h);
        slot_r <= in_slot;
        if (in_action == btct_pkg::ACT_BEGIN) begin
          frame_r  <= in_time;
          pcount_r <= '0;
          mark_r   <= '0;
        end
      end
      if (cmd.scan_clear) begin
        rd_r <= '0;
        wr_r <= '0;
        pi_r <= '0;
      end
      if (cmd.compact) begin
        // move the kept entry down, preserving order
        if (!drop) begin
          left_r[wi]  <= left_r[ri];
          top_r[wi]   <= top_r[ri];
          wide_r[wi]  <= wide_r[ri];
          tall_r[wi]  <= tall_r[ri];
          ctime_r[wi] <= ctime_r[ri];
          mtime_r[wi] <= mtime_r[ri];
          mark_r[wi]  <= mark_r[ri];
          wr_r <= wr_r + NB'(1);
        end
        rd_r <= rd_r + NB'(1);
      end
      if (cmd.finish_compact) begin
        count_r <= wr_r;
      end
      if (cmd.match_step) begin
        if (hit_box) begin
          mark_r[ri]  <= 1'b1;
          mtime_r[ri] <= frame_r;
        end else begin
          rd_r <= rd_r + NB'(1);
        end
      end
      if (cmd.queue_blob) begin
        px_r[pcount_r[PI-1:0]] <= x_r;
        py_r[pcount_r[PI-1:0]] <= y_r;
        ps_r[pcount_r[PI-1:0]] <= w_r;
        pcount_r <= pcount_r + PN'(1);
      end
      if (cmd.append_step) begin
        left_r[count_r[IB-1:0]]  <= px_r[pix];
        top_r[count_r[IB-1:0]]   <= py_r[pix];
        wide_r[count_r[IB-1:0]]  <= ps_r[pix];
        tall_r[count_r[IB-1:0]]  <= ps_r[pix];
        ctime_r[count_r[IB-1:0]] <= frame_r;
        mtime_r[count_r[IB-1:0]] <= frame_r;
        count_r <= count_r + NB'(1);
        pi_r    <= pi_r + PN'(1);
      end
      if (cmd.clear_marks) begin
        mark_r   <= '0;
        pcount_r <= '0;
        rd_r     <= '0;
      end
      if (cmd.set_bounds && ({1'b0, slot_r} < (5)'(count_r))) begin
        left_r[slot_r[IB-1:0]] <= x_r;
        top_r[slot_r[IB-1:0]]  <= y_r;
        wide_r[slot_r[IB-1:0]] <= w_r;
        tall_r[slot_r[IB-1:0]] <= h_r;
      end
      if (cmd.rpt_step) begin
        rd_r <= rd_r + NB'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NB'(btct_pkg::MAX_BOXES)) else $error("box count overflow");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PN'(btct_pkg::MAX_PENDING)) else $error("pending count overflow");
  a_keep_le_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compact |-> wr_r <= rd_r) else $error("compaction write passed read");

endmodule

[hdl/btct_ctrl.sv]
// sequencer for the correlation table: accepts beats, steps the datapath
// depends on btct_pkg
`timescale 1ns / 1ps

module btct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [1:0]           in_action,
  output logic                 in_ready,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [2:0]           kind,
  output logic                 is_box,
  output logic                 last,
  input  logic [1:0]           act_r,
  output btct_pkg::dp_cmd_t    cmd,
  input  btct_pkg::dp_stat_t   stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_BEGIN, S_BLOB, S_END_PRUNE, S_END_FIX, S_APPEND, S_MARKS,
    S_SET, S_RPT, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic        valid_r, valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        box_r, box_nxt, last_r, last_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_tvalid = valid_r;
  assign kind       = kind_r;
  assign is_box     = box_r;
  assign last       = last_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    box_nxt   = box_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.scan_clear = 1'b1;
          unique case (btct_pkg::action_t'(in_action))
            btct_pkg::ACT_BEGIN: state_nxt = S_BEGIN;
            btct_pkg::ACT_BLOB:  state_nxt = S_BLOB;
            btct_pkg::ACT_END:   state_nxt = S_END_PRUNE;
            default:             state_nxt = S_SET;
          endcase
        end
      end
      S_BEGIN: begin
        if (stat.scan_done) begin
          cmd.finish_compact = 1'b1;
          kind_nxt = btct_pkg::KIND_ACK; box_nxt = 1'b0; last_nxt = 1'b1;
          valid_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.compact = 1'b1;
        end
      end
      S_BLOB: begin
        if (stat.scan_done) begin
          box_nxt = 1'b0; last_nxt = 1'b1; valid_nxt = 1'b1; state_nxt = S_OUT;
          if (stat.pend_full) begin
            kind_nxt = btct_pkg::KIND_DROPPED;
          end else begin
            kind_nxt = btct_pkg::KIND_QUEUED;
            cmd.queue_blob = 1'b1;
          end
        end else begin
          cmd.match_step = 1'b1;
          if (stat.hit) begin
            kind_nxt = btct_pkg::KIND_MATCH; box_nxt = 1'b1; last_nxt = 1'b1;
            valid_nxt = 1'b1; state_nxt = S_OUT;
          end
        end
      end
      S_END_PRUNE: begin
        cmd.stale_mode = 1'b1;
        if (stat.scan_done) begin
          cmd.finish_compact = 1'b1;
          state_nxt = S_END_FIX;
        end else begin
          cmd.compact = 1'b1;
        end
      end
      S_END_FIX: begin
        state_nxt = S_APPEND;
      end
      S_APPEND: begin
        if (stat.pend_done) begin
          state_nxt = S_MARKS;
        end else begin
          cmd.append_step = 1'b1;
        end
      end
      S_MARKS: begin
        cmd.clear_marks = 1'b1;
        state_nxt = S_RPT;
      end
      S_RPT: begin
        valid_nxt = 1'b1; state_nxt = S_OUT;
        if (stat.empty) begin
          kind_nxt = btct_pkg::KIND_EMPTY; box_nxt = 1'b0; last_nxt = 1'b1;
        end else begin
          kind_nxt = btct_pkg::KIND_RECORD; box_nxt = 1'b1; last_nxt = stat.rpt_last;
        end
      end
      S_SET: begin
        cmd.set_bounds = 1'b1;
        kind_nxt = btct_pkg::KIND_ACK; box_nxt = 1'b0; last_nxt = 1'b1;
        valid_nxt = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          valid_nxt = 1'b0;
          if (act_r == btct_pkg::ACT_END && !last_r) begin
            cmd.rpt_step = 1'b1;
            state_nxt = S_RPT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      kind_r  <= btct_pkg::KIND_ACK;
      box_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      kind_r  <= kind_nxt;
      box_r   <= box_nxt;
      last_r  <= last_nxt;
    end
  end

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT) else $error("result outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("accepted while busy");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.compact, cmd.match_step, cmd.append_step, cmd.rpt_step}))
    else $error("overlapping datapath steps");

endmodule

[hdl/blob_track_correlation_table.sv]
// top level of the blob track correlation table
// depends on btct_pkg, btct_ctrl, btct_datapath
//
// channel  dir  tdata fields (low bit up)                          tuser/tlast
// in_      in   current_time, pos_x, pos_y, box_width, box_height,  tuser=action
//               slot (84 bits, padded to 88)
// out_     out  out_slot, out_x, out_y, out_width, out_height,       tuser=result_kind
//               first_seen, last_seen (116 bits, padded to 120)    tlast=last
// cfg_     in   stale_limit (32)
//
// one item at a time: a new input beat is taken only in idle, after the last result beat
// of the item before it. blob scans the boxes until a hit or the end, begin frame compacts
// out bad-aspect boxes, end frame prunes stale boxes, appends pending blobs and then
// reports every box, and set bounds acknowledges; each result waits for out_tready.
// reset is synchronous active low and clears counts, marks and frame time.
`timescale 1ns / 1ps

module blob_track_correlation_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // current_time, pos_x, pos_y, box_width, box_height, slot
  input  logic [1:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // out_slot, out_x, out_y, out_width, out_height,
                                   // first_seen, last_seen
  output logic [2:0]   out_tuser,  // result_kind
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  btct_pkg::dp_cmd_t  cmd;
  btct_pkg::dp_stat_t stat;
  logic [31:0] stale_r;
  logic [1:0]  act_r;
  logic        is_box;
  logic [3:0]  rd_slot;
  logic [11:0] rd_x, rd_y, rd_w, rd_h;
  logic [31:0] rd_first, rd_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= btct_pkg::STALE_RESET;
    end else if (cfg_we) begin
      stale_r <= cfg_wdata;
    end
  end

  btct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .in_action(in_tuser), .in_ready(in_tready),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .kind(out_tuser),
    .is_box(is_box), .last(out_tlast), .act_r(act_r), .cmd(cmd), .stat(stat)
  );

  btct_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .stale_limit(stale_r),
    .in_action(in_tuser), .in_time(in_tdata[31:0]), .in_x(in_tdata[43:32]),
    .in_y(in_tdata[55:44]), .in_w(in_tdata[67:56]), .in_h(in_tdata[79:68]),
    .in_slot(in_tdata[83:80]), .act_r(act_r), .rd_slot(rd_slot), .rd_x(rd_x),
    .rd_y(rd_y), .rd_w(rd_w), .rd_h(rd_h), .rd_first(rd_first), .rd_last(rd_last)
  );

  // box fields are read live from the table; it does not change while a beat waits
  assign out_tdata = is_box ?
    {4'd0, rd_last, rd_first, rd_h, rd_w, rd_y, rd_x, rd_slot} : 120'd0;

endmodule

[tb/tb.sv]
// self-checking testbench for blob_track_correlation_table
// depends on btct_pkg and the block's rtl; carries its own tracking-table predictor
`timescale 1ns / 1ps

module tb;

  typedef struct {
    btct_pkg::action_t act;
    logic [31:0] stamp;
    logic [11:0] x, y, w, h;
    logic [3:0]  slot;
  } beat_t;

  typedef struct {
    btct_pkg::kind_t kind;
    logic [3:0]  slot;
    logic [11:0] x, y, w, h;
    logic [31:0] first, latest;
    logic        last;
  } rec_t;

  logic         clk = 0, rst_n = 0;
  logic         in_tvalid = 0, in_tready;
  logic [87:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid, out_tready = 0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 0;
  logic [31:0]  cfg_wdata = '0;

  blob_track_correlation_table uut (.*);

  always #5 clk = ~clk;

  beat_t beat_q[$];
  rec_t  track_q[$];
  beat_t cur_beat;
  int    errors = 0;
  bit    idle_en = 1;

  // predicted table state
  logic [11:0] t_left[16], t_top[16], t_wide[16], t_tall[16];
  logic [31:0] t_born[16], t_seen[16];
  bit          t_pair[16];
  int          t_cnt = 0;
  logic [11:0] q_x[16], q_y[16], q_size[16];
  int          q_cnt = 0;
  logic [31:0] frame_now = 0, stale_lim = btct_pkg::STALE_RESET;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void add_rec(rec_t r);
    track_q.insert(track_q.size(), r);
  endfunction

  function automatic rec_t plain(btct_pkg::kind_t k);
    rec_t r;
    r = '{kind: k, slot: 0, x: 0, y: 0, w: 0, h: 0, first: 0, latest: 0, last: 1};
    return r;
  endfunction

  function automatic rec_t box_rec(btct_pkg::kind_t k, int i, bit lst);
    rec_t r;
    r = '{kind: k, slot: i[3:0], x: t_left[i], y: t_top[i], w: t_wide[i], h: t_tall[i],
          first: t_born[i], latest: t_seen[i], last: lst};
    return r;
  endfunction

  function automatic void move_slot(int d, int s);
    t_left[d] = t_left[s]; t_top[d] = t_top[s]; t_wide[d] = t_wide[s];
    t_tall[d] = t_tall[s]; t_born[d] = t_born[s]; t_seen[d] = t_seen[s];
    t_pair[d] = t_pair[s];
  endfunction

  function automatic void track_step(beat_t b);
    int keep;
    int w, h;
    bit found;
    keep = 0;
    found = 0;
    case (b.act)
      btct_pkg::ACT_BEGIN: begin
        frame_now = b.stamp;
        q_cnt = 0;
        for (int i = 0; i < t_cnt; i++) begin
          w = t_wide[i];
          h = t_tall[i];
          t_pair[i] = 0;
          if (w == 0 || h == 0 || !(10 * w < 6 * h || 10 * w > 17 * h)) begin
            if (keep != i) move_slot(keep, i);
            keep++;
          end
        end
        t_cnt = keep;
        add_rec(plain(btct_pkg::KIND_ACK));
      end
      btct_pkg::ACT_BLOB: begin
        for (int i = 0; i < t_cnt && !found; i++) begin
          if (!t_pair[i] && b.x >= t_left[i] && int'(b.x) < int'(t_left[i]) + int'(t_wide[i])
              && b.y >= t_top[i] && int'(b.y) < int'(t_top[i]) + int'(t_tall[i])) begin
            t_pair[i] = 1;
            t_seen[i] = frame_now;
            add_rec(box_rec(btct_pkg::KIND_MATCH, i, 1));
            found = 1;
          end
        end
        if (!found) begin
          if (q_cnt < btct_pkg::MAX_PENDING) begin
            q_x[q_cnt] = b.x; q_y[q_cnt] = b.y; q_size[q_cnt] = b.w;
            q_cnt++;
            add_rec(plain(btct_pkg::KIND_QUEUED));
          end else begin
            add_rec(plain(btct_pkg::KIND_DROPPED));
          end
        end
      end
      btct_pkg::ACT_END: begin
        for (int i = 0; i < t_cnt; i++) begin
          if (t_pair[i] || (frame_now - t_seen[i]) < stale_lim) begin
            if (keep != i) move_slot(keep, i);
            keep++;
          end
        end
        t_cnt = keep;
        for (int i = 0; i < q_cnt && t_cnt < btct_pkg::MAX_BOXES; i++) begin
          t_left[t_cnt] = q_x[i]; t_top[t_cnt] = q_y[i];
          t_wide[t_cnt] = q_size[i]; t_tall[t_cnt] = q_size[i];
          t_born[t_cnt] = frame_now; t_seen[t_cnt] = frame_now;
          t_cnt++;
        end
        q_cnt = 0;
        for (int i = 0; i < t_cnt; i++) t_pair[i] = 0;
        if (t_cnt == 0) add_rec(plain(btct_pkg::KIND_EMPTY));
        for (int i = 0; i < t_cnt; i++)
          add_rec(box_rec(btct_pkg::KIND_RECORD, i, i == t_cnt - 1));
      end
      default: begin
        if (b.slot < t_cnt) begin
          t_left[b.slot] = b.x; t_top[b.slot] = b.y;
          t_wide[b.slot] = b.w; t_tall[b.slot] = b.h;
        end
        add_rec(plain(btct_pkg::KIND_ACK));
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) track_step(cur_beat);
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() > 0 && !(idle_en && $urandom_range(99) < 30)) begin
          cur_beat = beat_q.pop_front();
          in_tvalid <= 1;
          in_tuser <= cur_beat.act;
          in_tdata <= {4'b0, cur_beat.slot, cur_beat.h, cur_beat.w, cur_beat.y, cur_beat.x,
                       cur_beat.stamp};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (track_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = track_q.pop_front();
        if (out_tuser != e.kind) report($sformatf("kind %0d exp %0d", out_tuser, e.kind));
        if (out_tdata[3:0] != e.slot) report($sformatf("slot %0d exp %0d", out_tdata[3:0], e.slot));
        if (out_tdata[15:4] != e.x) report($sformatf("x %0d exp %0d", out_tdata[15:4], e.x));
        if (out_tdata[27:16] != e.y) report($sformatf("y %0d exp %0d", out_tdata[27:16], e.y));
        if (out_tdata[39:28] != e.w) report($sformatf("width %0d exp %0d", out_tdata[39:28], e.w));
        if (out_tdata[51:40] != e.h) report($sformatf("height %0d exp %0d", out_tdata[51:40], e.h));
        if (out_tdata[83:52] != e.first)
          report($sformatf("first_seen %0h exp %0h", out_tdata[83:52], e.first));
        if (out_tdata[115:84] != e.latest)
          report($sformatf("last_seen %0h exp %0h", out_tdata[115:84], e.latest));
        if (out_tdata[119:116] != 0) report("padding bits not zero");
        if (out_tlast != e.last) report($sformatf("tlast %0b exp %0b", out_tlast, e.last));
      end
    end
    out_tready <= rst_n && !(idle_en && $urandom_range(99) < 30);
  end

  task automatic push(btct_pkg::action_t a, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                      logic [31:0] w, logic [31:0] h, logic [31:0] s);
    beat_t b;
    b = '{act: a, stamp: t, x: x[11:0], y: y[11:0], w: w[11:0], h: h[11:0], slot: s[3:0]};
    beat_q.insert(beat_q.size(), b);
  endtask

  // check after the edge has settled so a beat just taken from the queue is seen
  task automatic drain();
    #1;
    while (beat_q.size() > 0 || in_tvalid || track_q.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_stale(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    stale_lim = v;
  endtask

  logic [31:0] clock_t = 0;

  // one frame of random content; blob points mostly aimed at predicted boxes
  task automatic rand_frame();
    int n, j;
    logic [31:0] x, y, w;
    if ($urandom_range(9) == 0) clock_t = $urandom;
    else clock_t = clock_t + $urandom_range(1500);
    if ($urandom_range(19) != 0)
      push(btct_pkg::ACT_BEGIN, clock_t, $urandom, $urandom, $urandom, $urandom, $urandom);
    n = ($urandom_range(7) == 0) ? $urandom_range(18) : $urandom_range(5);
    for (int k = 0; k < n; k++) begin
      w = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1, 300);
      if (t_cnt > 0 && $urandom_range(99) < 60) begin
        j = $urandom_range(t_cnt - 1);
        x = 32'(t_left[j]) + ((t_wide[j] > 0) ? $urandom_range(32'(t_wide[j]) - 1) : 32'd0);
        y = 32'(t_top[j]) + ((t_tall[j] > 0) ? $urandom_range(32'(t_tall[j]) - 1) : 32'd0);
      end else begin
        x = $urandom;
        y = $urandom;
      end
      push(btct_pkg::ACT_BLOB, $urandom, x, y, w, $urandom, $urandom);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(1, 400);
        push(btct_pkg::ACT_SET, $urandom, $urandom, $urandom, w,
             ($urandom_range(1)) ? w : $urandom_range(1, 800), $urandom_range(15));
      end
    end
    if ($urandom_range(19) != 0)
      push(btct_pkg::ACT_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    repeat (3) @(posedge clk);

    // directed: extremes, empty table, zero-size box, bad aspect, unoccupied slot
    push(btct_pkg::ACT_END, 0, 0, 0, 0, 0, 0);
    push(btct_pkg::ACT_SET, 0, 5, 5, 5, 5, 0);
    push(btct_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 0, 0, 32'hfff, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 32'hfff, 32'hfff, 0, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 100, 100, 50, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 100, 100, 50, 0, 0);
    push(btct_pkg::ACT_END, 32'hffffffff, 32'hfff, 32'hfff, 32'hfff, 32'hfff, 32'hf);
    push(btct_pkg::ACT_BEGIN, 10, 0, 0, 0, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 120, 120, 9, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 120, 120, 9, 0, 0);
    push(btct_pkg::ACT_BLOB, 0, 120, 120, 9, 0, 0);
    push(btct_pkg::ACT_SET, 32'hffffffff, 10, 10, 10, 20, 2);
    push(btct_pkg::ACT_SET, 0, 32'hfff, 32'hfff, 32'hfff, 32'hfff, 3);
    push(btct_pkg::ACT_SET, 0, 1, 1, 1, 1, 32'hf);
    push(btct_pkg::ACT_END, 0, 0, 0, 0, 0, 0);
    push(btct_pkg::ACT_BEGIN, 2000, 0, 0, 0, 0, 0);
    push(btct_pkg::ACT_END, 0, 0, 0, 0, 0, 0);
    clock_t = 32'd2000;
    drain();

    // long stretch with no idling on either side
    idle_en = 0;
    write_stale(32'hffffffff);
    repeat (6) rand_frame();
    drain();
    idle_en = 1;

    write_stale(32'd0);
    repeat (5) rand_frame();
    drain();

    write_stale(32'd1500);
    clock_t = 32'hfffffc00;
    repeat (8) begin
      rand_frame();
      if ($urandom_range(2) == 0) drain();
    end
    drain();

    write_stale($urandom);
    repeat (5) rand_frame();
    drain();

    write_stale(32'd1000);
    repeat (6) rand_frame();
    drain();

    if (errors == 0 && track_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
